[design/block_buffer_cache_lookup_alloc_assert.svh]
// Assertion helpers shared by the cache tag manager.
`ifndef BLOCK_BUFFER_CACHE_LOOKUP_ALLOC_ASSERT_SVH
`define BLOCK_BUFFER_CACHE_LOOKUP_ALLOC_ASSERT_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define BBC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define BBC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/bbc_pkg.sv]
`default_nettype none

package bbc_pkg;

    // Operation codes of a request.
    localparam logic [1:0] OP_LOOKUP  = 2'd0;
    localparam logic [1:0] OP_GET     = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;
    localparam logic [1:0] OP_MARK    = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_NOFREE   = 2'd2;
    localparam logic [1:0] ST_BADREL   = 2'd3;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_WALK_RD,
        S_WALK_CMP,
        S_UNLINK,
        S_TAIL_RD,
        S_TAIL_CMP,
        S_APPEND,
        S_IDX_RD,
        S_IDX_OP
    } t_state;

    // One tag entry: device and block number.
    typedef struct packed {
        logic [15:0] dev;
        logic [31:0] blk;
    } t_tag;

    // Per-slot status: reference count, dirty and uptodate bits.
    typedef struct packed {
        logic [7:0] refs;
        logic       dirty;
        logic       valid;
    } t_meta;

endpackage

`default_nettype wire

[design/block_buffer_cache_lookup_alloc.sv]
`default_nettype none
`include "block_buffer_cache_lookup_alloc_assert.svh"

// Block buffer cache tag manager with an LRU free list.
// A request is taken when start is high and busy is low; its operands are
// the i_ fields. Exactly one result follows, shown for one cycle with
// o_valid high; the receiver cannot stall it.
// Tags, per-slot status and the free-list links sit in RAMs with one write
// port and a registered read port, so every visit of a slot takes a read
// state and a compare state of the one sequencer and its shared tag comparator.
// A lookup or get scans the slots from slot 0 and stops at the first hit; a
// get miss then walks the free list from its head to the first unreferenced
// entry and relinks the victim at the tail. Release or mark reads the
// addressed slot; an index beyond the buffers is answered from idle.
// After reset the block clears the RAMs and builds the free list, with busy
// high; then it waits for requests.
module block_buffer_cache_lookup_alloc
    import bbc_pkg::*;
#(
    parameter int NUM_BUFFERS = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [15:0] i_dev,
    input  wire logic [31:0] i_block_number,
    input  wire logic [7:0]  i_buffer_index,
    input  wire logic        i_dirty_in,
    input  wire logic        i_uptodate_in,
    output logic             o_valid,
    output logic [1:0]       o_status,
    output logic             o_hit,
    output logic [7:0]       o_slot,
    output logic             o_slot_uptodate,
    output logic [7:0]       o_ref_count,
    output logic             o_writeback_req,
    output logic [15:0]      o_writeback_dev
);

    localparam int AW = $clog2(NUM_BUFFERS);
    localparam logic [AW-1:0] LAST = AW'(NUM_BUFFERS - 1);

    t_state r_state, n_state;
    logic [AW-1:0] r_ra, n_ra;
    logic [AW-1:0] r_k, n_k;
    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_vs, n_vs;
    logic [AW-1:0] r_p, n_p;
    logic [AW-1:0] r_n, n_n;
    logic [1:0]    r_op, n_op;
    t_tag          r_key, n_key;
    logic [AW-1:0] r_idx, n_idx;
    logic          r_dirty_in, n_dirty_in;
    logic          r_upd_in, n_upd_in;
    logic          r_wreq, n_wreq;
    logic [15:0]   r_wdev, n_wdev;

    logic          r_valid, n_valid;
    logic [1:0]    r_status, n_status;
    logic          r_hit, n_hit;
    logic [7:0]    r_slot, n_slot;
    logic          r_upd, n_upd;
    logic [7:0]    r_cnt, n_cnt;
    logic          r_oreq, n_oreq;
    logic [15:0]   r_odev, n_odev;

    // RAM ports.
    logic          tag_we, meta_we, nxt_we, prv_we;
    logic [AW-1:0] tag_wa, meta_wa, nxt_wa, prv_wa;
    t_tag          tag_wd, tag_rd;
    t_meta         meta_wd, meta_rd;
    logic [AW-1:0] nxt_wd, prv_wd, nxt_rd, prv_rd;
    logic          match;
    logic [7:0]    refs_inc;

    bbc_ram #(.WIDTH($bits(t_tag)), .DEPTH(NUM_BUFFERS)) u_tag_ram (
        .i_clk(i_clk), .i_we(tag_we), .i_waddr(tag_wa), .i_wdata(tag_wd),
        .i_raddr(r_ra), .o_rdata(tag_rd)
    );

    bbc_ram #(.WIDTH($bits(t_meta)), .DEPTH(NUM_BUFFERS)) u_meta_ram (
        .i_clk(i_clk), .i_we(meta_we), .i_waddr(meta_wa), .i_wdata(meta_wd),
        .i_raddr(r_ra), .o_rdata(meta_rd)
    );

    bbc_ram #(.WIDTH(AW), .DEPTH(NUM_BUFFERS)) u_next_ram (
        .i_clk(i_clk), .i_we(nxt_we), .i_waddr(nxt_wa), .i_wdata(nxt_wd),
        .i_raddr(r_ra), .o_rdata(nxt_rd)
    );

    bbc_ram #(.WIDTH(AW), .DEPTH(NUM_BUFFERS)) u_prev_ram (
        .i_clk(i_clk), .i_we(prv_we), .i_waddr(prv_wa), .i_wdata(prv_wd),
        .i_raddr(r_ra), .o_rdata(prv_rd)
    );

    // Shared comparator for the tag scan.
    bbc_tag_cmp u_cmp (
        .i_entry(tag_rd),
        .i_key(r_key),
        .o_match(match)
    );

    assign refs_inc = (meta_rd.refs == 8'hFF) ? meta_rd.refs : meta_rd.refs + 8'd1;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ra    <= '0;
            r_head  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ra    <= n_ra;
            r_head  <= n_head;
            r_valid <= n_valid;
        end
    end

    // Operand, working and result registers.
    always_ff @(posedge i_clk) begin
        r_k        <= n_k;
        r_vs       <= n_vs;
        r_p        <= n_p;
        r_n        <= n_n;
        r_op       <= n_op;
        r_key      <= n_key;
        r_idx      <= n_idx;
        r_dirty_in <= n_dirty_in;
        r_upd_in   <= n_upd_in;
        r_wreq     <= n_wreq;
        r_wdev     <= n_wdev;
        r_status   <= n_status;
        r_hit      <= n_hit;
        r_slot     <= n_slot;
        r_upd      <= n_upd;
        r_cnt      <= n_cnt;
        r_oreq     <= n_oreq;
        r_odev     <= n_odev;
    end

    // Sequencer: next state, RAM writes and the result.
    always_comb begin
        n_state    = r_state;
        n_ra       = r_ra;
        n_k        = r_k;
        n_head     = r_head;
        n_vs       = r_vs;
        n_p        = r_p;
        n_n        = r_n;
        n_op       = r_op;
        n_key      = r_key;
        n_idx      = r_idx;
        n_dirty_in = r_dirty_in;
        n_upd_in   = r_upd_in;
        n_wreq     = r_wreq;
        n_wdev     = r_wdev;
        n_valid    = 1'b0;
        n_status   = r_status;
        n_hit      = r_hit;
        n_slot     = r_slot;
        n_upd      = r_upd;
        n_cnt      = r_cnt;
        n_oreq     = r_oreq;
        n_odev     = r_odev;
        tag_we     = 1'b0;
        tag_wa     = r_ra;
        tag_wd     = '0;
        meta_we    = 1'b0;
        meta_wa    = r_ra;
        meta_wd    = '0;
        nxt_we     = 1'b0;
        nxt_wa     = r_ra;
        nxt_wd     = '0;
        prv_we     = 1'b0;
        prv_wa     = r_ra;
        prv_wd     = '0;

        case (r_state)
            // Clear the tags and chain every slot into the free list.
            S_CLEAR: begin
                tag_we  = 1'b1;
                meta_we = 1'b1;
                nxt_we  = 1'b1;
                prv_we  = 1'b1;
                nxt_wd  = (r_ra == LAST) ? '0 : r_ra + AW'(1);
                prv_wd  = (r_ra == '0) ? LAST : r_ra - AW'(1);
                if (r_ra == LAST) begin
                    n_ra    = '0;
                    n_state = S_IDLE;
                end else begin
                    n_ra = r_ra + AW'(1);
                end
            end

            // Take a request.
            S_IDLE: begin
                if (start) begin
                    n_op       = i_opcode;
                    n_key.dev  = i_dev;
                    n_key.blk  = i_block_number;
                    n_idx      = AW'(i_buffer_index);
                    n_dirty_in = i_dirty_in;
                    n_upd_in   = i_uptodate_in;
                    if (i_opcode == OP_LOOKUP || i_opcode == OP_GET) begin
                        n_ra    = '0;
                        n_state = S_SCAN_RD;
                    end else if (32'(i_buffer_index) >= 32'(NUM_BUFFERS)) begin
                        n_valid  = 1'b1;
                        n_status = ST_NOTFOUND;
                        n_hit    = 1'b0;
                        n_slot   = 8'd0;
                        n_upd    = 1'b0;
                        n_cnt    = 8'd0;
                        n_oreq   = 1'b0;
                        n_odev   = 16'd0;
                    end else begin
                        n_ra    = AW'(i_buffer_index);
                        n_state = S_IDX_RD;
                    end
                end
            end

            S_SCAN_RD: begin
                n_state = S_SCAN_CMP;
            end

            // Compare one tag; the lowest matching slot wins.
            S_SCAN_CMP: begin
                if (match) begin
                    meta_we      = 1'b1;
                    meta_wd      = meta_rd;
                    meta_wd.refs = refs_inc;
                    n_valid      = 1'b1;
                    n_status     = ST_OK;
                    n_hit        = 1'b1;
                    n_slot       = 8'(r_ra);
                    n_upd        = meta_rd.valid;
                    n_cnt        = refs_inc;
                    n_oreq       = 1'b0;
                    n_odev       = 16'd0;
                    n_state      = S_IDLE;
                end else if (r_ra != LAST) begin
                    n_ra    = r_ra + AW'(1);
                    n_state = S_SCAN_RD;
                end else if (r_op == OP_GET) begin
                    n_ra    = r_head;
                    n_k     = '0;
                    n_state = S_WALK_RD;
                end else begin
                    n_valid  = 1'b1;
                    n_status = ST_NOTFOUND;
                    n_hit    = 1'b0;
                    n_slot   = 8'd0;
                    n_upd    = 1'b0;
                    n_cnt    = 8'd0;
                    n_oreq   = 1'b0;
                    n_odev   = 16'd0;
                    n_state  = S_IDLE;
                end
            end

            S_WALK_RD: begin
                n_state = S_WALK_CMP;
            end

            // Walk the free list for the first unreferenced slot.
            S_WALK_CMP: begin
                if (meta_rd.refs == 8'd0) begin
                    n_vs          = r_ra;
                    n_p           = prv_rd;
                    n_n           = nxt_rd;
                    n_wreq        = meta_rd.dirty;
                    n_wdev        = meta_rd.dirty ? tag_rd.dev : 16'd0;
                    tag_we        = 1'b1;
                    tag_wd        = r_key;
                    meta_we       = 1'b1;
                    meta_wd.refs  = 8'd1;
                    meta_wd.dirty = 1'b0;
                    meta_wd.valid = 1'b0;
                    n_state       = S_UNLINK;
                end else if (r_k == LAST) begin
                    n_valid  = 1'b1;
                    n_status = ST_NOFREE;
                    n_hit    = 1'b0;
                    n_slot   = 8'd0;
                    n_upd    = 1'b0;
                    n_cnt    = 8'd0;
                    n_oreq   = 1'b0;
                    n_odev   = 16'd0;
                    n_state  = S_IDLE;
                end else begin
                    n_ra    = nxt_rd;
                    n_k     = r_k + AW'(1);
                    n_state = S_WALK_RD;
                end
            end

            // Take the victim out of the list.
            S_UNLINK: begin
                nxt_we = 1'b1;
                nxt_wa = r_p;
                nxt_wd = r_n;
                prv_we = 1'b1;
                prv_wa = r_n;
                prv_wd = r_p;
                if (r_head == r_vs) begin
                    n_head = r_n;
                    n_ra   = r_n;
                end else begin
                    n_ra = r_head;
                end
                n_state = S_TAIL_RD;
            end

            S_TAIL_RD: begin
                n_state = S_TAIL_CMP;
            end

            // Point the victim at the head and the current tail.
            S_TAIL_CMP: begin
                nxt_we  = 1'b1;
                nxt_wa  = r_vs;
                nxt_wd  = r_head;
                prv_we  = 1'b1;
                prv_wa  = r_vs;
                prv_wd  = prv_rd;
                n_p     = prv_rd;
                n_state = S_APPEND;
            end

            // Link the victim in as the new tail and report it.
            S_APPEND: begin
                nxt_we   = 1'b1;
                nxt_wa   = r_p;
                nxt_wd   = r_vs;
                prv_we   = 1'b1;
                prv_wa   = r_head;
                prv_wd   = r_vs;
                n_valid  = 1'b1;
                n_status = ST_OK;
                n_hit    = 1'b0;
                n_slot   = 8'(r_vs);
                n_upd    = 1'b0;
                n_cnt    = 8'd1;
                n_oreq   = r_wreq;
                n_odev   = r_wdev;
                n_state  = S_IDLE;
            end

            S_IDX_RD: begin
                n_state = S_IDX_OP;
            end

            // Release or mark an addressed slot.
            S_IDX_OP: begin
                n_valid = 1'b1;
                n_hit   = 1'b0;
                n_slot  = 8'(r_idx);
                n_oreq  = 1'b0;
                n_odev  = 16'd0;
                n_state = S_IDLE;
                if (r_op == OP_RELEASE) begin
                    n_upd = meta_rd.valid;
                    if (meta_rd.refs == 8'd0) begin
                        n_status = ST_BADREL;
                        n_cnt    = 8'd0;
                    end else begin
                        meta_we      = 1'b1;
                        meta_wd      = meta_rd;
                        meta_wd.refs = meta_rd.refs - 8'd1;
                        n_status     = ST_OK;
                        n_cnt        = meta_rd.refs - 8'd1;
                    end
                end else begin
                    meta_we       = 1'b1;
                    meta_wd.refs  = meta_rd.refs;
                    meta_wd.dirty = r_dirty_in;
                    meta_wd.valid = r_upd_in;
                    n_status      = ST_OK;
                    n_upd         = r_upd_in;
                    n_cnt         = meta_rd.refs;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy            = (r_state != S_IDLE);
    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_hit           = r_hit;
    assign o_slot          = r_slot;
    assign o_slot_uptodate = r_upd;
    assign o_ref_count     = r_cnt;
    assign o_writeback_req = r_oreq;
    assign o_writeback_dev = r_odev;

    // A result only appears once the sequencer is back at rest.
    `BBC_ASSERT_IMP(a_valid_idle, o_valid, r_state == S_IDLE, "result while busy")
    // A hit is always a successful operation on a referenced slot.
    `BBC_ASSERT_IMP(a_hit_ok, o_valid && o_hit, o_status == ST_OK && o_ref_count != 8'd0, "bad hit")
    // A lookup or get always scans the tags.
    `BBC_ASSERT_NXT(a_scan, start && !busy && (i_opcode == OP_LOOKUP || i_opcode == OP_GET), busy, "no scan")
    // A writeback request only comes with a fresh allocation.
    `BBC_ASSERT_IMP(a_wb, o_valid && o_writeback_req, !o_hit && o_ref_count == 8'd1, "stray writeback")

endmodule

`default_nettype wire

[design/bbc_ram.sv]
`default_nettype none

module bbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[design/bbc_tag_cmp.sv]
`default_nettype none

module bbc_tag_cmp
    import bbc_pkg::*;
(
    input  wire t_tag i_entry,
    input  wire t_tag i_key,
    output logic      o_match
);

    // Device zero stands for no device and never matches.
    assign o_match = (i_key.dev != 16'd0) && (i_entry.dev == i_key.dev)
                     && (i_entry.blk == i_key.blk);

endmodule

`default_nettype wire

[dv/tb_block_buffer_cache_lookup_alloc.sv]
`default_nettype none

// Buffer cache tag model: tags, counts, state bits and the LRU free list.
class cache_scoreboard;
    logic [15:0] dev_tag   [256];
    logic [31:0] blk_tag   [256];
    logic [7:0]  refs      [256];
    logic        dirty     [256];
    logic        uptodate  [256];
    logic [7:0]  nxt       [256];
    logic [7:0]  prv       [256];
    logic [7:0]  head;
    logic [66:0] pending [$];
    int          errors;
    int          checked;

    function void clear();
        for (int i = 0; i < 256; i++) begin
            dev_tag[i] = 0; blk_tag[i] = 0; refs[i] = 0; dirty[i] = 0;
            uptodate[i] = 0; nxt[i] = 8'(i + 1); prv[i] = 8'(i - 1);
        end
        head = 0;
        pending.delete();
        errors = 0;
        checked = 0;
    endfunction

    // Works out the answer to one accepted request and queues it.
    function void note_request(logic [1:0] op, logic [15:0] dv, logic [31:0] bn,
                               logic [7:0] idx, logic di, logic ui);
        logic [1:0]  st;
        logic        ht, up, wr;
        logic [7:0]  sl, cnt, s, p, n, t;
        logic [15:0] wd;
        int          found;
        int          k;
        st = bbc_pkg::ST_OK; ht = 0; up = 0; wr = 0; sl = 0; cnt = 0; wd = 0;
        found = -1;
        if (op == bbc_pkg::OP_LOOKUP || op == bbc_pkg::OP_GET) begin
            if (dv != 0)
                for (int i = 0; i < 256 && found < 0; i++)
                    if (dev_tag[i] == dv && blk_tag[i] == bn) found = i;
            if (found >= 0) begin
                s = 8'(found);
                if (refs[s] != 8'hFF) refs[s]++;
                ht = 1; sl = s; up = uptodate[s]; cnt = refs[s];
            end else if (op == bbc_pkg::OP_LOOKUP) begin
                st = bbc_pkg::ST_NOTFOUND;
            end else begin
                s = head;
                for (k = 0; k < 256; k++) begin
                    if (refs[s] == 0) break;
                    s = nxt[s];
                end
                if (k == 256) begin
                    st = bbc_pkg::ST_NOFREE;
                end else begin
                    refs[s] = 1;
                    p = prv[s]; n = nxt[s];
                    nxt[p] = n; prv[n] = p;
                    if (head == s) head = n;
                    if (dirty[s]) begin wr = 1; wd = dev_tag[s]; end
                    dev_tag[s] = dv; blk_tag[s] = bn; dirty[s] = 0; uptodate[s] = 0;
                    t = prv[head];
                    nxt[s] = head; prv[s] = t; nxt[t] = s; prv[head] = s;
                    sl = s; cnt = 1;
                end
            end
        end else if (op == bbc_pkg::OP_RELEASE && refs[idx] == 0) begin
            st = bbc_pkg::ST_BADREL; sl = idx; up = uptodate[idx];
        end else begin
            if (op == bbc_pkg::OP_RELEASE) refs[idx]--;
            else begin dirty[idx] = di; uptodate[idx] = ui; end
            sl = idx; up = uptodate[idx]; cnt = refs[idx];
        end
        pending.push_back({st, ht, sl, up, cnt, wr, wd});
    endfunction

    task check_result(logic [66:0] got);
        logic [66:0] exp_r;
        if (pending.size() == 0) begin
            report("result with nothing outstanding", got, '0);
            return;
        end
        exp_r = pending.pop_front();
        checked++;
        if (got[36:0] !== exp_r[36:0]) report("result fields differ", got, exp_r);
    endtask

    task report(string what, logic [66:0] got, logic [66:0] exp_r);
        errors++;
        if (errors <= 30) begin
            $write("MISMATCH %s: got st=%0d hit=%0b slot=%0d upd=%0b cnt=%0d wb=%0b/%0h, ",
                   what, got[36:35], got[34], got[33:26], got[25], got[24:17], got[16],
                   got[15:0]);
            $display("want st=%0d hit=%0b slot=%0d upd=%0b cnt=%0d wb=%0b/%0h",
                     exp_r[36:35], exp_r[34], exp_r[33:26], exp_r[25],
                     exp_r[24:17], exp_r[16], exp_r[15:0]);
        end
    endtask
endclass

module tb_block_buffer_cache_lookup_alloc;
    import bbc_pkg::*;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        start = 0;
    logic [1:0]  i_opcode = 0;
    logic [15:0] i_dev = 0;
    logic [31:0] i_block_number = 0;
    logic [7:0]  i_buffer_index = 0;
    logic        i_dirty_in = 0;
    logic        i_uptodate_in = 0;
    wire         busy, o_valid, o_hit, o_slot_uptodate, o_writeback_req;
    wire [1:0]   o_status;
    wire [7:0]   o_slot, o_ref_count;
    wire [15:0]  o_writeback_dev;

    cache_scoreboard sb = new();
    int          gap_pct;
    int          sent;
    logic [15:0] recent_dev [8];
    logic [31:0] recent_blk [8];

    block_buffer_cache_lookup_alloc dut (.*);

    always #4 i_clk = ~i_clk;

    // Results cannot be held off, so every strobed cycle is checked.
    always @(posedge i_clk)
        if (i_rst_n && o_valid)
            sb.check_result({30'd0, o_status, o_hit, o_slot, o_slot_uptodate,
                             o_ref_count, o_writeback_req, o_writeback_dev});

    // Presents one request and holds it until the block is idle again, then
    // drops start before the next request may be driven.
    task automatic issue(logic [1:0] op, logic [15:0] dv, logic [31:0] bn,
                         logic [7:0] idx, logic di, logic ui);
        while ($urandom_range(99) < gap_pct) @(posedge i_clk);
        start <= 1; i_opcode <= op; i_dev <= dv; i_block_number <= bn;
        i_buffer_index <= idx; i_dirty_in <= di; i_uptodate_in <= ui;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_request(op, dv, bn, idx, di, ui);
        start <= 0;
        sent++;
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    // Mostly small device/block sets so that hits, evictions and full caches occur.
    task automatic random_request();
        int          r;
        logic [15:0] dv;
        logic [31:0] bn;
        r = $urandom_range(7);
        dv = recent_dev[r]; bn = recent_blk[r];
        if ($urandom_range(3) == 0) begin
            dv = 16'($urandom); bn = $urandom;
            if ($urandom_range(5) == 0) dv = 0;
            recent_dev[r] = dv; recent_blk[r] = bn;
        end else if ($urandom_range(2) == 0) begin
            bn = $urandom_range(3);
        end
        case ($urandom_range(9))
            0, 1:    issue(OP_LOOKUP, dv, bn, 8'($urandom), 1'($urandom), 1'($urandom));
            2, 3, 4: issue(OP_GET, dv, bn, 8'($urandom), 1'($urandom), 1'($urandom));
            5, 6:    issue(OP_RELEASE, 16'($urandom), $urandom,
                           ($urandom_range(1) ? sb.pending.size() > 0 ? 8'($urandom) :
                            8'($urandom_range(15)) : 8'($urandom_range(15))), 0, 0);
            default: issue(OP_MARK, 16'($urandom), $urandom, 8'($urandom_range(255)),
                           1'($urandom), 1'($urandom));
        endcase
    endtask

    initial begin
        #2000000000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        sb.clear();
        gap_pct = 0;
        sent = 0;
        for (int i = 0; i < 8; i++) begin
            recent_dev[i] = 16'($urandom_range(3) + 1); recent_blk[i] = $urandom;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;

        // Directed: extremes, device zero, marks and bad releases.
        issue(OP_LOOKUP, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 1, 1);
        issue(OP_GET, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 1, 1);
        issue(OP_GET, 0, 0, 0, 0, 0);
        issue(OP_LOOKUP, 0, 0, 0, 0, 0);
        issue(OP_MARK, 0, 0, 8'd1, 1, 1);
        issue(OP_LOOKUP, 16'hFFFF, 32'hFFFF_FFFF, 0, 0, 0);
        issue(OP_RELEASE, 0, 0, 8'd0, 0, 0);
        issue(OP_RELEASE, 0, 0, 8'd0, 0, 0);
        issue(OP_RELEASE, 0, 0, 8'd0, 0, 0);
        issue(OP_RELEASE, 0, 0, 8'hFF, 0, 0);
        issue(OP_MARK, 0, 0, 8'hFF, 1, 0);
        issue(OP_MARK, 0, 0, 8'd0, 1, 1);
        issue(OP_GET, 16'h1234, 32'h5, 0, 0, 0);
        for (int i = 0; i < 9; i++) issue(OP_GET, 16'h0001, 32'hA, 0, 0, 0);
        drain();

        // Fill the cache, evicting the dirty slot, so that a miss finds nothing to reclaim; then saturate a count.
        for (int i = 0; i < 256; i++) issue(OP_GET, 16'h00AA, i, 0, 0, 0);
        issue(OP_GET, 16'h00BB, 32'h1, 0, 0, 0);
        for (int i = 0; i < 250; i++) issue(OP_LOOKUP, 16'h0001, 32'hA, 0, 0, 0);
        for (int i = 0; i < 256; i += 2) issue(OP_RELEASE, 0, 0, 8'(i), 0, 0);
        drain();

        // Random phases with different sender gaps.
        for (int ph = 0; ph < 3; ph++) begin
            gap_pct = (ph == 0) ? 24 : (ph == 1) ? 84 : 0;
            for (int i = 0; i < 65; i++) random_request();
            drain();
        end

        repeat (20) @(posedge i_clk);
        $display("Covered %0d requests with %0d results checked: hits, misses, evictions,",
                 sent, sb.checked);
        $display("dirty writebacks, full-cache refusals and releases of free slots.");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

[filelist.f]
+incdir+design
design/bbc_pkg.sv
design/bbc_ram.sv
design/bbc_tag_cmp.sv
design/block_buffer_cache_lookup_alloc.sv
dv/tb_block_buffer_cache_lookup_alloc.sv
